// ----- hw/rtl/bsr_pkg.sv -----
`default_nettype none
package bsr_pkg;
  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_RECT  = 3'd2;
  localparam logic [2:0] KIND_CIRC  = 3'd3;
  localparam logic [2:0] KIND_TRI   = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;
  localparam int READ_BITS = 16;
  localparam int CW = 12;

  // Pixel write request from the sequencer to the canvas.
  typedef struct packed {
    logic                 en;
    logic signed [CW-1:0] row;
    logic signed [CW-1:0] col;
  } pix_req_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bsr_canvas.sv -----
`default_nettype none
module bsr_canvas #(
  parameter int CANVAS_ROWS = 30,
  parameter int CANVAS_COLS = 80,
  parameter int WORD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bsr_pkg::pix_req_t pix,
  input  wire logic clear_start,
  output logic clear_busy,
  input  wire logic rd_en,
  input  wire logic [$clog2(CANVAS_ROWS*((CANVAS_COLS+WORD_BITS-1)/WORD_BITS))-1:0] rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  output logic rmw_busy
);
  import bsr_pkg::*;
  localparam int WPR = (CANVAS_COLS + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = CANVAS_ROWS * WPR;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int BW = $clog2(WORD_BITS) > 0 ? $clog2(WORD_BITS) : 1;
  localparam int DW = DEPTH;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic clr_act;
  logic            s1;
  logic [AW-1:0]   s1_addr;
  logic [BW-1:0]   s1_bit;
  logic [WORD_BITS-1:0] q;
  logic in_c;
  logic [AW-1:0] wa;
  logic [BW-1:0] wb;
  logic [31:0] flat;

  assign in_c = pix.en && pix.row >= 0 && pix.row < CANVAS_ROWS
                && pix.col >= 0 && pix.col < CANVAS_COLS;
  assign flat = 32'(pix.row) * 32'(WPR) + 32'(pix.col) / WORD_BITS;
  assign wa = flat[AW-1:0];
  assign wb = BW'(32'(pix.col) % WORD_BITS);
  assign clear_busy = clr_act;
  assign rmw_busy = s1;
  assign rd_data = q;

  // Clearing pass: one word a cycle. Pixel writes are a read then a
  // write-back; the sequencer waits during the write-back cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_act <= 1'b1;
      clr_addr <= '0;
      s1 <= 1'b0;
    end else begin
      s1 <= in_c && !clr_act && !s1;
      if (clr_act) begin
        if (clr_addr == AW'(DW - 1)) clr_act <= 1'b0;
        clr_addr <= clr_addr + 1'b1;
      end else if (clear_start) begin
        clr_act <= 1'b1;
        clr_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_act) begin
      mem[clr_addr] <= '0;
    end else if (s1) begin
      mem[s1_addr] <= q | (WORD_BITS'(1) << s1_bit);
    end
    if (in_c && !s1) q <= mem[wa];
    else if (rd_en) q <= mem[rd_addr];
    s1_addr <= wa;
    s1_bit <= wb;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bitmap_shape_rasterizer_core.sv -----
`default_nettype none
// Bitmap shape rasterizer. A command is taken when start is high and busy
// is low; exactly one result word appears on pixel_word/out_of_range for
// one cycle with done high, and the receiver cannot stall it. Each pixel
// that lands on the canvas is plotted through a canvas read-modify-write;
// a position that falls off the canvas, and a circle position outside the
// ring, skips the write-back. A circle scans its full (2r+1)^2 box.
// Clear and reset sweep the canvas one word a cycle, CANVAS_ROWS times
// ceil(CANVAS_COLS/WORD_BITS) words; busy is high during that pass.
// A read takes up to ceil(READ_BITS/WORD_BITS)+1 word fetches of one memory
// port, one a cycle, and done rises after the last fetched word has landed.
module bitmap_shape_rasterizer_core #(
  parameter int CANVAS_ROWS = 30,
  parameter int CANVAS_COLS = 80,
  parameter int WORD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [2:0] kind,
  input  wire logic signed [9:0] row_a,
  input  wire logic signed [9:0] col_a,
  input  wire logic signed [9:0] row_b,
  input  wire logic signed [9:0] col_b,
  input  wire logic signed [9:0] row_c,
  input  wire logic signed [9:0] col_c,
  input  wire logic [7:0] radius,
  output logic done,
  output logic [15:0] pixel_word,
  output logic out_of_range
);
  import bsr_pkg::*;
  localparam int WPR = (CANVAS_COLS + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = CANVAS_ROWS * WPR;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int NRW = (READ_BITS + WORD_BITS - 1) / WORD_BITS + 1;
  localparam int CNTW = $clog2(NRW + 2) + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_LINE = 8'b00000010,
    S_RECT = 8'b00000100,
    S_CIRC = 8'b00001000,
    S_RDW  = 8'b00010000,
    S_SEG  = 8'b00100000,
    S_CLR  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state;
  logic [2:0] cmd;
  logic signed [CW-1:0] ra, ca, rb, cb, rc, cc;
  logic [7:0] rad;
  // line walker
  logic signed [CW-1:0] lr, lc, er, ec;
  logic signed [CW:0] dr, dc, e;
  logic sr, sc;
  logic [1:0] seg;
  // rect/circle counters
  logic signed [CW-1:0] i, j;
  logic [1:0] side;
  logic [17:0] lo, hi;
  logic signed [17:0] di, dj;
  logic [17:0] d2;
  // read
  logic [CNTW-1:0] rcnt;
  logic [READ_BITS+WORD_BITS*NRW-1:0] acc;
  logic [63:0] shifted;
  logic oor;

  pix_req_t pix;
  logic clear_start, clear_busy, rd_en, rmw_busy;
  logic [AW-1:0] rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [31:0] ra_flat;
  logic go;

  bsr_canvas #(.CANVAS_ROWS(CANVAS_ROWS), .CANVAS_COLS(CANVAS_COLS),
               .WORD_BITS(WORD_BITS)) u_canvas (
    .clk, .rst, .pix, .clear_start, .clear_busy,
    .rd_en, .rd_addr, .rd_data, .rmw_busy
  );

  assign busy = state != S_IDLE || clear_busy;
  // Plot advance only when the canvas is not in its write-back cycle.
  assign go = !rmw_busy;

  always_comb begin
    pix = '0;
    case (state)
      S_LINE: begin pix.en = go; pix.row = lr; pix.col = lc; end
      S_RECT: begin
        pix.en = go;
        case (side)
          2'd0: begin pix.row = ra; pix.col = i; end
          2'd1: begin pix.row = rb; pix.col = i; end
          2'd2: begin pix.row = i; pix.col = ca; end
          default: begin pix.row = i; pix.col = cb; end
        endcase
      end
      S_CIRC: begin
        pix.en = go && (rad == 8'd0 || (d2 > lo && d2 <= hi));
        pix.row = ra + i; pix.col = ca + j;
      end
      default: ;
    endcase
  end

  // The offsets are widened first so that the squares keep all their bits.
  assign di = 18'(i);
  assign dj = 18'(j);
  assign d2 = 18'(di * di) + 18'(dj * dj);
  assign ra_flat = 32'(ra) * 32'(WPR) + 32'(ca) / WORD_BITS + 32'(rcnt);
  assign rd_en = state == S_RDW && rcnt < CNTW'(NRW)
                 && (32'(ca) / WORD_BITS + 32'(rcnt)) < 32'(WPR);
  assign rd_addr = ra_flat[AW-1:0];
  assign clear_start = state == S_CLR;
  assign shifted = 64'(acc >> (32'(ca) % WORD_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= state == S_DONE;
      case (state)
        S_IDLE: if (start && !clear_busy) begin
          cmd <= kind;
          // A rectangle takes its corners in order.
          ra <= CW'((kind == KIND_RECT && row_a > row_b) ? row_b : row_a);
          rb <= CW'((kind == KIND_RECT && row_a > row_b) ? row_a : row_b);
          ca <= CW'((kind == KIND_RECT && col_a > col_b) ? col_b : col_a);
          cb <= CW'((kind == KIND_RECT && col_a > col_b) ? col_a : col_b);
          rc <= CW'(row_c); cc <= CW'(col_c);
          rad <= radius;
          seg <= 2'd0;
          rcnt <= '0;
          acc <= '0;
          case (kind)
            KIND_CLEAR: state <= S_CLR;
            KIND_LINE, KIND_TRI: begin
              lr <= CW'(row_a); lc <= CW'(col_a);
              er <= CW'(row_b); ec <= CW'(col_b);
              state <= S_SEG;
            end
            KIND_RECT: begin
              i <= CW'(col_a > col_b ? col_b : col_a);
              side <= 2'd0;
              state <= S_RECT;
            end
            KIND_CIRC: begin
              lo <= 18'(radius) * 18'(radius) - 18'(radius);
              hi <= 18'(radius) * 18'(radius) + 18'(radius);
              i <= -CW'(radius); j <= -CW'(radius);
              state <= S_CIRC;
            end
            KIND_READ: begin
              oor <= row_a < 0 || row_a >= CANVAS_ROWS || col_a < 0
                     || col_a >= CANVAS_COLS;
              state <= S_RDW;
            end
            default: begin
              oor <= 1'b0;
              state <= S_DONE;
            end
          endcase
        end
        S_CLR: state <= S_DONE;
        S_SEG: begin
          // Set up Bresenham terms for the current segment.
          dc <= ec > lc ? (CW+1)'(ec) - (CW+1)'(lc) : (CW+1)'(lc) - (CW+1)'(ec);
          dr <= er > lr ? (CW+1)'(er) - (CW+1)'(lr) : (CW+1)'(lr) - (CW+1)'(er);
          e <= (ec > lc ? (CW+1)'(ec) - (CW+1)'(lc) : (CW+1)'(lc) - (CW+1)'(ec))
             - (er > lr ? (CW+1)'(er) - (CW+1)'(lr) : (CW+1)'(lr) - (CW+1)'(er));
          sc <= lc < ec;
          sr <= lr < er;
          state <= S_LINE;
        end
        S_LINE: if (go) begin
          if (lr == er && lc == ec) begin
            if (cmd == KIND_TRI && seg != 2'd2) begin
              seg <= seg + 2'd1;
              if (seg == 2'd0) begin er <= rc; ec <= cc; end
              else begin er <= ra; ec <= ca; end
              state <= S_SEG;
            end else begin
              oor <= 1'b0;
              state <= S_DONE;
            end
          end else begin
            if ((e <<< 1) > -dr) lc <= sc ? lc + 1'b1 : lc - 1'b1;
            if ((e <<< 1) < dc) lr <= sr ? lr + 1'b1 : lr - 1'b1;
            e <= e - (((e <<< 1) > -dr) ? dr : '0) + (((e <<< 1) < dc) ? dc : '0);
          end
        end
        S_RECT: if (go) begin
          if (side[1] ? i == rb : i == cb) begin
            side <= side + 2'd1;
            i <= side == 2'd1 ? ra : (side == 2'd0 ? ca : ra);
            if (side == 2'd3) begin oor <= 1'b0; state <= S_DONE; end
          end else begin
            i <= i + 1'b1;
          end
        end
        S_CIRC: if (go) begin
          if (rad == 8'd0 || (i == CW'(rad) && j == CW'(rad))) begin
            oor <= 1'b0;
            state <= S_DONE;
          end else if (j == CW'(rad)) begin
            j <= -CW'(rad);
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_RDW: begin
          // Fetched word k lands in the cycle after its address.
          if (rcnt != '0 && 32'(rcnt) <= NRW
              && (32'(ca) / WORD_BITS + 32'(rcnt) - 1) < 32'(WPR))
            acc[(32'(rcnt)-1)*WORD_BITS +: WORD_BITS] <= rd_data;
          if (32'(rcnt) == NRW) state <= S_DONE;
          rcnt <= rcnt + 1'b1;
        end
        S_DONE: begin
          if (cmd == KIND_READ && !oor) begin
            pixel_word <= shifted[15:0];
          end else begin
            pixel_word <= '0;
          end
          out_of_range <= cmd == KIND_READ && oor;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
